// ===== rtl/poefk_pkg.sv =====
// ----------------------------------------------------------------------------
// poefk_pkg: shared types, constants and arithmetic helpers
// Word format, CORDIC tables and saturating arithmetic for the space-frame
// product-of-exponentials forward kinematics block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package poefk_pkg;

    localparam int WORD_BITS   = 32;
    localparam int FRAC_BITS   = 28;
    localparam int CORDIC_ITER = FRAC_BITS + 2;
    localparam int ITER_BITS   = $clog2(CORDIC_ITER);
    localparam int ANG_BITS    = WORD_BITS + 2;
    localparam int Q60_SHIFT   = 60 - FRAC_BITS;

    // stream packing
    localparam int IN_DATA_BITS  = 232;
    localparam int OUT_DATA_BITS = 4 * WORD_BITS;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic signed [ANG_BITS-1:0]  ang_t;
    typedef logic signed [63:0]          q60_t;
    typedef logic [CORDIC_ITER-1:0][63:0] atan_tab_t;

    localparam q60_t PI_Q60 = 64'sh3243F6A8885A308D;

    localparam q60_t  WMAX_Q = (64'sd1 <<< (WORD_BITS - 1)) - 64'sd1;
    localparam q60_t  WMIN_Q = -WMAX_Q - 64'sd1;
    localparam word_t WMAX_W = word_t'(WMAX_Q);
    localparam word_t WMIN_W = ~WMAX_W;
    localparam word_t ZERO_W = '0;
    localparam word_t ONE_W  = word_t'(64'sd1 <<< FRAC_BITS);

    localparam longint EPS_RAW = ((64'sd1 <<< FRAC_BITS) + 64'sd500000) / 64'sd1000000;
    localparam word_t  EPS_W   = (EPS_RAW < 1) ? word_t'(1) : word_t'(EPS_RAW);

    // Q60 value to word: round half up, then saturate
    function automatic word_t q60_round(q60_t v);
        q60_t t;
        t = (v + (64'sd1 <<< (Q60_SHIFT - 1))) >>> Q60_SHIFT;
        if (t > WMAX_Q)
            return WMAX_W;
        if (t < WMIN_Q)
            return WMIN_W;
        return t[WORD_BITS-1:0];
    endfunction

    localparam word_t TWO_PI_W  = q60_round(PI_Q60 <<< 1);
    localparam word_t PI_W      = q60_round(PI_Q60);
    localparam word_t HALF_PI_W = q60_round(PI_Q60 >>> 1);

    function automatic word_t sat_add(word_t a, word_t b);
        logic [WORD_BITS:0] s;
        s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1])
            return s[WORD_BITS] ? WMIN_W : WMAX_W;
        return s[WORD_BITS-1:0];
    endfunction

    function automatic word_t sat_sub(word_t a, word_t b);
        logic [WORD_BITS:0] s;
        s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1])
            return s[WORD_BITS] ? WMIN_W : WMAX_W;
        return s[WORD_BITS-1:0];
    endfunction

    // floor of a non-negative numerator over a positive denominator,
    // restoring shift and subtract, elaboration only
    function automatic longint div_floor(longint num, longint den);
        logic [63:0] r;
        logic [63:0] q;
        logic [63:0] n;
        logic [63:0] d;
        n = num;
        d = den;
        r = '0;
        q = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[62:0], n[b]};
            if (r >= d)
            begin
                r    = r - d;
                q[b] = 1'b1;
            end
        end
        return longint'(q);
    endfunction

    // arctangent table from the alternating series, evaluated at elaboration
    function automatic atan_tab_t make_atan_tab();
        atan_tab_t tab;
        longint    sum;
        longint    term;
        int        e;
        tab    = '0;
        tab[0] = PI_Q60 >>> 2;
        for (int i = 1; i < CORDIC_ITER; i++)
        begin
            sum = 0;
            for (int k = 0; k < 64; k++)
            begin
                e = 60 - i * (2 * k + 1);
                if (e >= 0)
                begin
                    term = div_floor(64'sd1 <<< e, longint'(2 * k + 1));
                    sum  = ((k & 1) == 1) ? sum - term : sum + term;
                end
            end
            tab[i] = sum;
        end
        return tab;
    endfunction

    localparam atan_tab_t ATAN_TAB = make_atan_tab();

    // start value: floor(2^120 / x), x the CORDIC gain in Q60, i.e. 1/gain in Q60
    function automatic q60_t make_kinv();
        q60_t        x;
        q60_t        y;
        q60_t        z;
        q60_t        dx;
        q60_t        dy;
        logic [63:0] d;
        logic [63:0] r;
        logic [63:0] q;
        x = 64'sd1 <<< 60;
        y = '0;
        z = '0;
        for (int i = 0; i < CORDIC_ITER; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - q60_t'(ATAN_TAB[i]);
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + q60_t'(ATAN_TAB[i]);
            end
        end
        d = x;
        r = '0;
        q = '0;
        for (int b = 120; b >= 0; b--)
        begin
            r = {r[62:0], (b == 120) ? 1'b1 : 1'b0};
            if (r >= d)
            begin
                r = r - d;
                if (b < 64)
                    q[b] = 1'b1;
            end
        end
        return q60_t'(q);
    endfunction

    localparam q60_t KINV_Q60 = make_kinv();

endpackage

`default_nettype wire

// ===== rtl/poefk_mulq.sv =====
// ----------------------------------------------------------------------------
// poefk_mulq: rounding, saturating fixed-point multiplier
// Two stages: magnitude product, then round half away from zero and clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module poefk_mulq (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              in_valid,
    input  poefk_pkg::word_t a,
    input  poefk_pkg::word_t b,
    output logic             out_valid,
    output poefk_pkg::word_t res
);
    import poefk_pkg::*;

    localparam int PW = 2 * WORD_BITS;
    localparam logic [PW-1:0] ROUND_K = PW'(1) << (FRAC_BITS - 1);
    localparam logic [PW-1:0] LIM_POS = PW'(WMAX_Q);

    logic [WORD_BITS-1:0] ua;
    logic [WORD_BITS-1:0] ub;
    logic [PW-1:0]        mag_reg;
    logic                 neg_reg;
    logic                 v1_reg;
    logic [PW-1:0]        mag_rnd;
    logic [PW-1:0]        lim;
    logic [PW-1:0]        msat;
    logic [WORD_BITS-1:0] rv;
    word_t                res_next;

    always_comb
    begin
        ua       = a[WORD_BITS-1] ? (~a + 1'b1) : a;
        ub       = b[WORD_BITS-1] ? (~b + 1'b1) : b;
        mag_rnd  = (mag_reg + ROUND_K) >> FRAC_BITS;
        lim      = LIM_POS + PW'(neg_reg);
        msat     = (mag_rnd > lim) ? lim : mag_rnd;
        rv       = msat[WORD_BITS-1:0];
        res_next = neg_reg ? word_t'(~rv + 1'b1) : word_t'(rv);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            out_valid <= 1'b0;
            mag_reg   <= '0;
            neg_reg   <= 1'b0;
            res       <= '0;
        end
        else
        begin
            v1_reg    <= in_valid;
            out_valid <= v1_reg;
            mag_reg   <= PW'(ua) * PW'(ub);
            neg_reg   <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
            res       <= res_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/poefk_cordic.sv =====
// ----------------------------------------------------------------------------
// poefk_cordic: iterative rotation-mode CORDIC
// One rotation per cycle at 60 fraction bits; gives cos in x, sin in y.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module poefk_cordic (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              start,
    input  poefk_pkg::ang_t  angle,
    output logic             done,
    output poefk_pkg::q60_t  x_out,
    output poefk_pkg::q60_t  y_out
);
    import poefk_pkg::*;

    logic                 busy_reg;
    logic [ITER_BITS-1:0] iter_reg;
    q60_t                 z_reg;
    q60_t                 dx;
    q60_t                 dy;
    q60_t                 at;

    always_comb
    begin
        dx = y_out >>> iter_reg;
        dy = x_out >>> iter_reg;
        at = q60_t'(ATAN_TAB[iter_reg]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            iter_reg <= '0;
            done     <= 1'b0;
            x_out    <= '0;
            y_out    <= '0;
            z_reg    <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                iter_reg <= '0;
                x_out    <= KINV_Q60;
                y_out    <= '0;
                z_reg    <= q60_t'(angle) <<< Q60_SHIFT;
            end
            else if (busy_reg)
            begin
                if (z_reg >= 0)
                begin
                    x_out <= x_out - dx;
                    y_out <= y_out + dy;
                    z_reg <= z_reg - at;
                end
                else
                begin
                    x_out <= x_out + dx;
                    y_out <= y_out - dy;
                    z_reg <= z_reg + at;
                end
                if (iter_reg == ITER_BITS'(CORDIC_ITER - 1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
                else
                begin
                    iter_reg <= iter_reg + 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/poe_forward_kinematics_space.sv =====
// ----------------------------------------------------------------------------
// poe_forward_kinematics_space: space-frame PoE forward kinematics
// Left-multiplies a running 3x4 pose by each joint's exponential, Q4.28.
// ----------------------------------------------------------------------------
// Usage:
//  Input stream: one item per handshake. tuser[0] = 0 loads a home pose row
//  (row_index, columns from wx, wy, wz, vx); tuser[0] = 1 is a joint step,
//  sent from the last joint to the first. tuser[1] starts a new chain from
//  the home pose; tlast marks joint one, after which three pose rows go out.
//  A load leaves the input ready. A joint step with a near-zero rotation
//  (prismatic) only tests the rotation and updates the translation; a
//  revolute step takes 30 CORDIC rotations plus about 110 products through
//  the single rounding multiplier, which issues one product per cycle and
//  drains between dependent phases. tready is low while a step runs.
//  Output stream: rows 0, 1, 2 on consecutive handshakes, tlast on row 2.
//  A stalled receiver holds the block; tdata stays steady until taken.
//  Reset: home pose becomes identity, running pose zeros, both streams idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module poe_forward_kinematics_space (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    s_axis_tvalid,
    output logic                                   s_axis_tready,
    // row_index, axis_wx, axis_wy, axis_wz, axis_vx, axis_vy, axis_vz, joint_angle
    input  wire  [poefk_pkg::IN_DATA_BITS-1:0]     s_axis_tdata,
    // mode, first_joint
    input  wire  [1:0]                             s_axis_tuser,
    input  wire                                    s_axis_tlast,
    output logic                                   m_axis_tvalid,
    input  wire                                    m_axis_tready,
    // pose_col0, pose_col1, pose_col2, pose_col3
    output logic [poefk_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata,
    // pose_row
    output logic [1:0]                             m_axis_tuser,
    output logic                                   m_axis_tlast
);
    import poefk_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_ISSUE, S_DRAIN, S_RED0, S_RED1, S_RED2, S_CSTART,
        S_CORD, S_SC0, S_SC1, S_SC2, S_COPY, S_DONE, S_OUT
    } state_t;

    typedef enum logic [2:0] {
        PH_TEST, PH_SMALL, PH_K2, PH_RG, PH_P, PH_NT
    } phase_t;

    typedef struct packed {
        phase_t     phase;
        logic       first;
        logic       last;
        logic [4:0] idx;
        word_t      init;
    } tag_t;

    localparam logic [1:0] ROW_LAST = 2'd2;

    state_t     state_reg;
    phase_t     phase_reg;
    logic [2:0] row_reg;
    logic [1:0] col_reg;
    logic [1:0] term_reg;
    logic       v1_reg;
    tag_t       tag1_reg;
    tag_t       tag2_reg;
    logic       last_reg;
    logic       neg_reg;
    logic [1:0] out_row_reg;
    logic       out_valid_reg;

    word_t w_reg [3];
    word_t v_reg [3];
    word_t th_reg;
    word_t home_reg [12];
    word_t pose_reg [12];
    word_t k2_reg [9];
    word_t rm_reg [9];
    word_t gm_reg [9];
    word_t p_reg [3];
    word_t nt_reg [12];
    word_t tvec_reg [3];
    word_t acc_reg;
    ang_t  ang_reg;
    word_t sn_reg;
    word_t cs_reg;
    word_t omc_reg;
    word_t tms_reg;

    // input fields
    logic [1:0] in_row;
    word_t      in_w [3];
    word_t      in_v [3];
    word_t      in_th;

    assign in_row  = s_axis_tdata[1:0];
    assign in_w[0] = s_axis_tdata[33:2];
    assign in_w[1] = s_axis_tdata[65:34];
    assign in_w[2] = s_axis_tdata[97:66];
    assign in_v[0] = s_axis_tdata[129:98];
    assign in_v[1] = s_axis_tdata[161:130];
    assign in_v[2] = s_axis_tdata[193:162];
    assign in_th   = s_axis_tdata[225:194];

    // skew matrix of w
    word_t k1 [9];
    always_comb
    begin
        k1[0] = ZERO_W;
        k1[1] = sat_sub(ZERO_W, w_reg[2]);
        k1[2] = w_reg[1];
        k1[3] = w_reg[2];
        k1[4] = ZERO_W;
        k1[5] = sat_sub(ZERO_W, w_reg[0]);
        k1[6] = sat_sub(ZERO_W, w_reg[1]);
        k1[7] = w_reg[0];
        k1[8] = ZERO_W;
    end

    function automatic logic [4:0] idx3(logic [2:0] r, logic [1:0] c);
        return 5'({r, 1'b0}) + 5'(r) + 5'(c);
    endfunction

    // operand selection for the shared multiplier
    logic [4:0] ea;
    logic [4:0] eb;
    logic [4:0] erg;
    logic [4:0] erg_lo;
    logic [2:0] row_g;
    word_t      op_a;
    word_t      op_b;
    word_t      op_init;
    logic [4:0] op_idx;
    logic [1:0] nterm_m1;
    logic [1:0] ncol_m1;
    logic [2:0] nrow_m1;

    always_comb
    begin
        ea       = idx3(row_reg, term_reg);
        eb       = idx3({1'b0, term_reg}, col_reg);
        erg      = idx3(row_reg, col_reg);
        erg_lo   = (erg >= 5'd9) ? erg - 5'd9 : erg;
        row_g    = row_reg - 3'd3;
        op_a     = ZERO_W;
        op_b     = ZERO_W;
        op_init  = ZERO_W;
        op_idx   = '0;
        nterm_m1 = 2'd0;
        ncol_m1  = 2'd2;
        nrow_m1  = 3'd0;
        case (phase_reg)
            PH_TEST:
            begin
                op_a   = w_reg[col_reg];
                op_b   = th_reg;
                op_idx = 5'(col_reg);
            end
            PH_SMALL:
            begin
                op_a    = v_reg[col_reg];
                op_b    = th_reg;
                op_init = pose_reg[{col_reg, 2'd3}];
                op_idx  = 5'({col_reg, 2'd3});
            end
            PH_K2:
            begin
                op_a     = k1[ea[3:0]];
                op_b     = k1[eb[3:0]];
                op_idx   = erg;
                nterm_m1 = 2'd2;
                nrow_m1  = 3'd2;
            end
            PH_RG:
            begin
                nterm_m1 = 2'd1;
                nrow_m1  = 3'd5;
                op_idx   = erg;
                if (row_reg < 3'd3)
                begin
                    op_a    = (term_reg == 2'd0) ? sn_reg : omc_reg;
                    op_init = (row_reg[1:0] == col_reg) ? ONE_W : ZERO_W;
                end
                else
                begin
                    op_a    = (term_reg == 2'd0) ? omc_reg : tms_reg;
                    op_init = (row_g[1:0] == col_reg) ? th_reg : ZERO_W;
                end
                op_b = (term_reg == 2'd0) ? k1[erg_lo[3:0]] : k2_reg[erg_lo[3:0]];
            end
            PH_P:
            begin
                op_a     = gm_reg[ea[3:0]];
                op_b     = v_reg[term_reg];
                op_idx   = 5'(row_reg);
                nterm_m1 = 2'd2;
                ncol_m1  = 2'd0;
                nrow_m1  = 3'd2;
            end
            PH_NT:
            begin
                // translation column takes p as a product with one
                if (term_reg == 2'd3)
                begin
                    op_a = p_reg[row_reg[1:0]];
                    op_b = ONE_W;
                end
                else
                begin
                    op_a = rm_reg[ea[3:0]];
                    op_b = pose_reg[{term_reg, col_reg}];
                end
                op_idx   = 5'({row_reg[1:0], col_reg});
                nterm_m1 = (col_reg == 2'd3) ? 2'd3 : 2'd2;
                ncol_m1  = 2'd3;
                nrow_m1  = 3'd2;
            end
            default:
            begin
                op_a = ZERO_W;
            end
        endcase
    end

    logic end_term;
    logic end_col;
    logic end_row;
    logic issue;

    assign end_term = (term_reg == nterm_m1);
    assign end_col  = (col_reg == ncol_m1);
    assign end_row  = (row_reg == nrow_m1);
    assign issue    = (state_reg == S_ISSUE);

    logic  mul_valid;
    word_t mul_res;

    poefk_mulq u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (issue),
        .a         (op_a),
        .b         (op_b),
        .out_valid (mul_valid),
        .res       (mul_res)
    );

    logic cord_start;
    logic cord_done;
    q60_t cord_x;
    q60_t cord_y;

    assign cord_start = (state_reg == S_CSTART);

    poefk_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cord_start),
        .angle (ang_reg),
        .done  (cord_done),
        .x_out (cord_x),
        .y_out (cord_y)
    );

    // accumulate stage
    word_t acc_sum;
    assign acc_sum = sat_add(tag2_reg.first ? tag2_reg.init : acc_reg, mul_res);

    logic near_zero;
    always_comb
    begin
        near_zero = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            if (!(tvec_reg[i] > -EPS_W && tvec_reg[i] < EPS_W))
                near_zero = 1'b0;
        end
    end

    ang_t th_ext;
    assign th_ext = ang_t'(th_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_TEST;
            row_reg       <= '0;
            col_reg       <= '0;
            term_reg      <= '0;
            v1_reg        <= 1'b0;
            tag1_reg      <= '0;
            tag2_reg      <= '0;
            last_reg      <= 1'b0;
            neg_reg       <= 1'b0;
            out_row_reg   <= '0;
            out_valid_reg <= 1'b0;
            th_reg        <= '0;
            acc_reg       <= '0;
            ang_reg       <= '0;
            sn_reg        <= '0;
            cs_reg        <= '0;
            omc_reg       <= '0;
            tms_reg       <= '0;
            for (int i = 0; i < 3; i++)
            begin
                w_reg[i]    <= '0;
                v_reg[i]    <= '0;
                p_reg[i]    <= '0;
                tvec_reg[i] <= '0;
            end
            for (int i = 0; i < 9; i++)
            begin
                k2_reg[i] <= '0;
                rm_reg[i] <= '0;
                gm_reg[i] <= '0;
            end
            for (int i = 0; i < 12; i++)
            begin
                home_reg[i] <= (i == 0 || i == 5 || i == 10) ? ONE_W : ZERO_W;
                pose_reg[i] <= '0;
                nt_reg[i]   <= '0;
            end
        end
        else
        begin
            v1_reg   <= issue;
            tag1_reg <= '{phase: phase_reg, first: (term_reg == 2'd0), last: end_term,
                          idx: op_idx, init: op_init};
            tag2_reg <= tag1_reg;

            if (mul_valid)
            begin
                acc_reg <= acc_sum;
                if (tag2_reg.last)
                begin
                    case (tag2_reg.phase)
                        PH_TEST:  tvec_reg[tag2_reg.idx[1:0]] <= acc_sum;
                        PH_SMALL: pose_reg[tag2_reg.idx[3:0]] <= acc_sum;
                        PH_K2:    k2_reg[tag2_reg.idx[3:0]]   <= acc_sum;
                        PH_RG:
                        begin
                            if (tag2_reg.idx >= 5'd9)
                                gm_reg[4'(tag2_reg.idx - 5'd9)] <= acc_sum;
                            else
                                rm_reg[tag2_reg.idx[3:0]] <= acc_sum;
                        end
                        PH_P:     p_reg[tag2_reg.idx[1:0]]    <= acc_sum;
                        PH_NT:    nt_reg[tag2_reg.idx[3:0]]   <= acc_sum;
                        default:  ;
                    endcase
                end
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        if (!s_axis_tuser[0])
                        begin
                            if (in_row != 2'd3)
                            begin
                                home_reg[{in_row, 2'd0}] <= in_w[0];
                                home_reg[{in_row, 2'd1}] <= in_w[1];
                                home_reg[{in_row, 2'd2}] <= in_w[2];
                                home_reg[{in_row, 2'd3}] <= in_v[0];
                            end
                        end
                        else
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                w_reg[i] <= in_w[i];
                                v_reg[i] <= in_v[i];
                            end
                            th_reg   <= in_th;
                            last_reg <= s_axis_tlast;
                            if (s_axis_tuser[1])
                            begin
                                for (int i = 0; i < 12; i++)
                                    pose_reg[i] <= home_reg[i];
                            end
                            phase_reg <= PH_TEST;
                            state_reg <= S_ISSUE;
                        end
                    end
                end
                S_ISSUE:
                begin
                    if (end_term)
                    begin
                        term_reg <= '0;
                        if (end_col)
                        begin
                            col_reg <= '0;
                            if (end_row)
                            begin
                                row_reg   <= '0;
                                state_reg <= S_DRAIN;
                            end
                            else
                            begin
                                row_reg <= row_reg + 3'd1;
                            end
                        end
                        else
                        begin
                            col_reg <= col_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        term_reg <= term_reg + 2'd1;
                    end
                end
                S_DRAIN:
                begin
                    if (!v1_reg && !mul_valid)
                    begin
                        case (phase_reg)
                            PH_TEST:
                            begin
                                if (near_zero)
                                begin
                                    phase_reg <= PH_SMALL;
                                    state_reg <= S_ISSUE;
                                end
                                else
                                begin
                                    state_reg <= S_RED0;
                                end
                            end
                            PH_SMALL: state_reg <= S_DONE;
                            PH_K2:
                            begin
                                phase_reg <= PH_RG;
                                state_reg <= S_ISSUE;
                            end
                            PH_RG:
                            begin
                                phase_reg <= PH_P;
                                state_reg <= S_ISSUE;
                            end
                            PH_P:
                            begin
                                phase_reg <= PH_NT;
                                state_reg <= S_ISSUE;
                            end
                            PH_NT:    state_reg <= S_COPY;
                            default:  state_reg <= S_IDLE;
                        endcase
                    end
                end
                // truncating remainder by 2pi, then into [-pi, pi]
                S_RED0:
                begin
                    if (th_ext >= ang_t'(TWO_PI_W))
                        ang_reg <= th_ext - ang_t'(TWO_PI_W);
                    else if (th_ext <= -ang_t'(TWO_PI_W))
                        ang_reg <= th_ext + ang_t'(TWO_PI_W);
                    else
                        ang_reg <= th_ext;
                    state_reg <= S_RED1;
                end
                S_RED1:
                begin
                    if (ang_reg > ang_t'(PI_W))
                        ang_reg <= ang_reg - ang_t'(TWO_PI_W);
                    else if (ang_reg < -ang_t'(PI_W))
                        ang_reg <= ang_reg + ang_t'(TWO_PI_W);
                    state_reg <= S_RED2;
                end
                // fold into [-pi/2, pi/2]; sine and cosine flip sign
                S_RED2:
                begin
                    neg_reg <= 1'b0;
                    if (ang_reg > ang_t'(HALF_PI_W))
                    begin
                        ang_reg <= ang_reg - ang_t'(PI_W);
                        neg_reg <= 1'b1;
                    end
                    else if (ang_reg < -ang_t'(HALF_PI_W))
                    begin
                        ang_reg <= ang_reg + ang_t'(PI_W);
                        neg_reg <= 1'b1;
                    end
                    state_reg <= S_CSTART;
                end
                S_CSTART: state_reg <= S_CORD;
                S_CORD:
                begin
                    if (cord_done)
                        state_reg <= S_SC0;
                end
                S_SC0:
                begin
                    cs_reg    <= q60_round(cord_x);
                    sn_reg    <= q60_round(cord_y);
                    state_reg <= S_SC1;
                end
                S_SC1:
                begin
                    if (neg_reg)
                    begin
                        cs_reg <= sat_sub(ZERO_W, cs_reg);
                        sn_reg <= sat_sub(ZERO_W, sn_reg);
                    end
                    state_reg <= S_SC2;
                end
                S_SC2:
                begin
                    omc_reg   <= sat_sub(ONE_W, cs_reg);
                    tms_reg   <= sat_sub(th_reg, sn_reg);
                    phase_reg <= PH_K2;
                    state_reg <= S_ISSUE;
                end
                S_COPY:
                begin
                    for (int i = 0; i < 12; i++)
                        pose_reg[i] <= nt_reg[i];
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (last_reg)
                    begin
                        out_row_reg   <= '0;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_OUT:
                begin
                    if (m_axis_tready)
                    begin
                        if (out_row_reg == ROW_LAST)
                        begin
                            out_valid_reg <= 1'b0;
                            state_reg     <= S_IDLE;
                        end
                        else
                        begin
                            out_row_reg <= out_row_reg + 2'd1;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_row_reg;
    assign m_axis_tlast  = (out_row_reg == ROW_LAST);
    assign m_axis_tdata  = {pose_reg[{out_row_reg, 2'd3}], pose_reg[{out_row_reg, 2'd2}],
                            pose_reg[{out_row_reg, 2'd1}], pose_reg[{out_row_reg, 2'd0}]};

endmodule

`default_nettype wire

// ===== rtl/poefk_checker.sv =====
// ----------------------------------------------------------------------------
// poefk_checker: port-level checks for the forward kinematics block
// Watches the two streams and flags ordering or holding slips.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module poefk_checker (
    input wire                                 clk,
    input wire                                 rst_n,
    input wire                                 s_axis_tvalid,
    input wire                                 s_axis_tready,
    input wire [1:0]                           s_axis_tuser,
    input wire                                 m_axis_tvalid,
    input wire                                 m_axis_tready,
    input wire [poefk_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
    input wire [1:0]                           m_axis_tuser,
    input wire                                 m_axis_tlast
);

    // a stalled output item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item changed while stalled");

    // one item at a time: never taking input while a pose goes out
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input accepted during pose output");

    // tlast marks row two only
    a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 2'd2)))
        else $error("tlast not on row two");

    // rows follow back to back
    a_rows_follow: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid && (m_axis_tuser == $past(m_axis_tuser) + 2'd1))
        else $error("pose rows out of order");

    // a home row load completes at once
    a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tuser[0] |=> s_axis_tready)
        else $error("load item stalled the input");

endmodule

bind poe_forward_kinematics_space poefk_checker u_poefk_checker (.*);

`default_nettype wire
